// ===== design/sah_pkg.sv =====
// Package for the sample address histogram: request, response and chain
// token types plus fixed constants. No dependencies.
package sah_pkg;

   // Payloads shorter than this cannot carry an address
   localparam logic [15:0] MIN_PAYLOAD = 16'd8;
   // Saturation value of hit and skip counters
   localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [63:0] sample_address;
      logic [15:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [7:0]  entry_index;
      logic [31:0] entry_hits;
      logic        is_new_entry;
      logic        dropped_full;
      logic        was_skipped;
      logic [8:0]  distinct_entries;
      logic [31:0] skipped_total;
   } rsp_type;

   // Lookup token walking down the cell chain
   typedef struct packed {
      logic        valid;
      logic        found;
      logic [63:0] addr;
      logic [31:0] hits;
   } token_type;

endpackage

// ===== design/sah_cell.sv =====
// One table entry of the histogram chain: stored address, hit count and a
// token stage. Depends on sah_pkg.
module sah_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 8,
   parameter int CNT_W = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sah_pkg::token_type       token_in,
   input  logic [IDX_W-1:0]         idx_in,
   input  logic [CNT_W-1:0]         fill_count,
   input  logic                     wr_en,
   input  logic [63:0]              wr_addr,
   output sah_pkg::token_type       token_out,
   output logic [IDX_W-1:0]         idx_out
);

   logic [63:0]        addr_ff;
   logic [31:0]        hits_ff;
   sah_pkg::token_type token_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic               filled;
   logic               match;
   logic               is_slot;
   logic [31:0]        hits_in;

   // entry is live once the fill count has passed it
   assign filled  = CNT_W'(INDEX) < fill_count;
   assign is_slot = CNT_W'(INDEX) == fill_count;
   assign match   = token_in.valid && !token_in.found && filled &&
                    (addr_ff == token_in.addr);
   assign hits_in = (hits_ff == sah_pkg::COUNT_MAX) ? hits_ff : hits_ff + 32'd1;

   // entry storage: append at the fill slot, bump on a hit
   always_ff @(posedge clock) begin
      if (wr_en && is_slot) begin
         addr_ff <= wr_addr;
         hits_ff <= 32'd1;
      end else if (match) begin
         hits_ff <= hits_in;
      end
   end

   // token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff.valid <= token_in.valid;
      end
      token_ff.addr  <= token_in.addr;
      token_ff.found <= token_in.found | match;
      token_ff.hits  <= match ? hits_in : token_in.hits;
      idx_ff         <= match ? IDX_W'(INDEX) : idx_in;
   end

   assign token_out = token_ff;
   assign idx_out   = idx_ff;

endmodule

// ===== design/sample_address_histogram.sv =====
// Sample address histogram top level: request/response control and the
// chain of table cells. Depends on sah_pkg and sah_cell.
//
// Usage: each request on req_ carries a sample address and payload length.
// A payload under 8 bytes is counted as skipped and never enters the table.
// Otherwise a lookup token walks the chain of ENTRIES cells, one cell per
// cycle; the matching cell bumps its saturating count, and at the chain end
// a miss appends the address in the next free cell, or is dropped when the
// table is full. Exactly one response leaves on rsp_ for each request.
// A skipped request's result is registered, then moved to the output register;
// a table request's result waits on the token's walk down the chain.
// One request is in the table at a time; the next is accepted once the last
// result has moved on. A finished response waits in the output
// register while rsp_ready is low; a new request is still accepted, and its
// response is held internally until the output register frees up.
// Reset empties the table (fill count zero), clears the skip counter and
// drops any request or response in flight.
module sample_address_histogram #(
   parameter int ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sah_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sah_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_EMIT} state_type;

   state_type          state_ff,     state_in;
   logic [CNT_W-1:0]   fill_ff,      fill_in;
   logic [31:0]        skip_ff,      skip_in;
   sah_pkg::token_type inject_ff,    inject_in;
   sah_pkg::rsp_type   res_ff,       res_in;
   sah_pkg::rsp_type   rsp_ff,       rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   sah_pkg::token_type token_chain [ENTRIES+1];
   logic [IDX_W-1:0]   idx_chain   [ENTRIES+1];

   sah_pkg::token_type tail;
   logic               full;
   logic               wr_en;
   logic               req_fire;

   assign token_chain[0] = inject_ff;
   assign idx_chain[0]   = '0;
   assign tail           = token_chain[ENTRIES];

   // cell chain
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      sah_cell #(
         .INDEX (g),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .token_in   (token_chain[g]),
         .idx_in     (idx_chain[g]),
         .fill_count (fill_ff),
         .wr_en      (wr_en),
         .wr_addr    (tail.addr),
         .token_out  (token_chain[g+1]),
         .idx_out    (idx_chain[g+1])
      );
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign full      = (fill_ff == CNT_W'(ENTRIES));
   assign wr_en     = (state_ff == ST_SEARCH) && tail.valid && !tail.found && !full;

   // next-state and result logic
   always_comb begin
      state_in           = state_ff;
      fill_in            = fill_ff;
      skip_in            = skip_ff;
      inject_in          = inject_ff;
      inject_in.valid    = 1'b0;
      res_in             = res_ff;
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.payload_length < sah_pkg::MIN_PAYLOAD) begin
                  if (skip_ff != sah_pkg::COUNT_MAX) begin
                     skip_in = skip_ff + 32'd1;
                  end
                  res_in                  = '0;
                  res_in.was_skipped      = 1'b1;
                  res_in.distinct_entries = 9'(fill_ff);
                  res_in.skipped_total    = skip_in;
                  state_in                = ST_EMIT;
               end else begin
                  inject_in.valid = 1'b1;
                  inject_in.found = 1'b0;
                  inject_in.addr  = req_data.sample_address;
                  inject_in.hits  = '0;
                  state_in        = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (tail.valid) begin
               res_in               = '0;
               res_in.skipped_total = skip_ff;
               if (tail.found) begin
                  res_in.entry_index      = 8'(idx_chain[ENTRIES]);
                  res_in.entry_hits       = tail.hits;
                  res_in.distinct_entries = 9'(fill_ff);
               end else if (!full) begin
                  fill_in                 = CNT_W'(fill_ff + 1'b1);
                  res_in.entry_index      = 8'(fill_ff);
                  res_in.entry_hits       = 32'd1;
                  res_in.is_new_entry     = 1'b1;
                  res_in.distinct_entries = 9'(fill_in);
               end else begin
                  res_in.dropped_full     = 1'b1;
                  res_in.distinct_entries = 9'(fill_ff);
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, counters and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fill_ff         <= '0;
         skip_ff         <= '0;
         inject_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         fill_ff         <= fill_in;
         skip_ff         <= skip_in;
         inject_ff.valid <= inject_in.valid;
         rsp_valid_ff    <= rsp_valid_in;
      end
      inject_ff.found <= inject_in.found;
      inject_ff.addr  <= inject_in.addr;
      inject_ff.hits  <= inject_in.hits;
      res_ff          <= res_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
